/* src/hlef_pkg.sv */
// Package for the head/length/end frame extractor.
// Buffer sizing, frame constants and action codes; no dependencies.
package hlef_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int MAX_COPY     = 64;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int LEN_W  = 16;
    localparam int FLEN_W = LEN_W + 1;

    localparam logic [7:0] HEAD_BYTE      = 8'hBB;
    localparam logic [7:0] END_BYTE       = 8'h7E;
    localparam int         FRAME_OVERHEAD = 7;

    localparam int OFF_LEN_HI  = 3;
    localparam int OFF_LEN_LO  = 4;
    localparam int OFF_PAYLOAD = 5;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

endpackage

/* src/hlef_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/hlef_offset_unit.sv */
// Shared circular-offset adder: read pointer plus scan offset, wrapped to the buffer.
// Serves every read address and every read-pointer advance. Depends on hlef_pkg.
module hlef_offset_unit (
    input  hlef_pkg::t_addr i_base,
    input  hlef_pkg::t_addr i_offset,
    output hlef_pkg::t_addr o_sum
);

    assign o_sum = i_base + i_offset;

endmodule

/* src/head_length_end_frame_extractor.sv */
// Top level of the head/length/end frame extractor: byte buffer and take sequencer.
// Depends on hlef_pkg, hlef_ram and hlef_offset_unit.
//
// A push or clear completes in S_IDLE. A take walks the buffer through one RAM read
// port and one shared offset adder: it tests each byte for a head and drops it if
// not; for a head it checks the length and the end byte, then reads and emits each
// payload word and drops the frame. Results appear one per strobe and cannot be
// held off by the receiver. busy stays high until the take ends.
module head_length_end_frame_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_request_len,
    output logic       o_strobe,
    output logic [7:0] o_payload_byte,
    output logic [6:0] o_copied_len,
    output logic       o_status,
    output logic       o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_H_RD, S_H_CHK, S_L3_RD, S_L4_RD, S_L_CHK,
        S_E_RD, S_E_CHK, S_P_RD, S_P_OUT, S_DROP
    } t_state;

    t_state r_state, n_state;
    hlef_pkg::t_addr r_rp, n_rp, r_wp, n_wp, r_off, n_off;
    hlef_pkg::t_cnt  r_fill, n_fill, r_dropn, n_dropn;
    logic [7:0] r_len_hi, n_len_hi;
    hlef_pkg::t_cnt  r_flen, n_flen;
    logic [6:0] r_want, n_want, r_copy, n_copy, r_idx, n_idx;
    logic r_done, n_done;
    logic r_strobe, n_strobe, r_status, n_status, r_last, n_last;
    logic [7:0] r_pbyte, n_pbyte;
    logic [6:0] r_copied, n_copied;

    logic       w_accept, w_we;
    logic [7:0] w_q;
    hlef_pkg::t_addr w_sum;
    logic [hlef_pkg::FLEN_W-1:0] w_flen, w_fill_ext;
    logic [hlef_pkg::LEN_W-1:0]  w_pl;
    logic [6:0] w_idx_inc;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_we     = w_accept && (i_action == hlef_pkg::ACT_PUSH)
                      && (r_fill < hlef_pkg::CNT_W'(hlef_pkg::BUFFER_DEPTH));

    hlef_offset_unit u_offset (
        .i_base   (r_rp),
        .i_offset (r_off),
        .o_sum    (w_sum)
    );

    hlef_ram #(
        .WIDTH (8),
        .DEPTH (hlef_pkg::BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (i_data_byte),
        .i_raddr (w_sum),
        .o_rdata (w_q)
    );

    assign w_pl       = {r_len_hi, w_q};
    assign w_flen     = {1'b0, w_pl} + hlef_pkg::FLEN_W'(hlef_pkg::FRAME_OVERHEAD);
    assign w_fill_ext = hlef_pkg::FLEN_W'(r_fill);
    assign w_idx_inc  = r_idx + 7'd1;

    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_off    = r_off;
        n_fill   = r_fill;
        n_dropn  = r_dropn;
        n_len_hi = r_len_hi;
        n_flen   = r_flen;
        n_want   = r_want;
        n_copy   = r_copy;
        n_idx    = r_idx;
        n_done   = r_done;
        n_strobe = 1'b0;
        n_status = r_status;
        n_last   = r_last;
        n_pbyte  = r_pbyte;
        n_copied = r_copied;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        hlef_pkg::ACT_PUSH: begin
                            if (w_we) begin
                                n_wp   = r_wp + hlef_pkg::ADDR_W'(1);
                                n_fill = r_fill + hlef_pkg::CNT_W'(1);
                            end
                        end
                        hlef_pkg::ACT_TAKE: begin
                            n_want  = (i_request_len > 7'(hlef_pkg::MAX_COPY))
                                      ? 7'(hlef_pkg::MAX_COPY) : i_request_len;
                            n_off   = '0;
                            n_done  = 1'b0;
                            n_state = S_H_RD;
                        end
                        hlef_pkg::ACT_CLEAR: begin
                            n_rp   = '0;
                            n_wp   = '0;
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_H_RD: begin
                if (r_fill == '0) begin
                    n_strobe = 1'b1;
                    n_pbyte  = '0;
                    n_copied = '0;
                    n_status = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_H_CHK;
                end
            end
            S_H_CHK: begin
                if (w_q != hlef_pkg::HEAD_BYTE) begin
                    n_off   = hlef_pkg::ADDR_W'(1);
                    n_dropn = hlef_pkg::CNT_W'(1);
                    n_state = S_DROP;
                end else if (r_fill < hlef_pkg::CNT_W'(hlef_pkg::FRAME_OVERHEAD)) begin
                    n_strobe = 1'b1;
                    n_pbyte  = '0;
                    n_copied = '0;
                    n_status = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_off   = hlef_pkg::ADDR_W'(hlef_pkg::OFF_LEN_HI);
                    n_state = S_L3_RD;
                end
            end
            S_L3_RD: begin
                n_off   = hlef_pkg::ADDR_W'(hlef_pkg::OFF_LEN_LO);
                n_state = S_L4_RD;
            end
            S_L4_RD: begin
                n_len_hi = w_q;
                n_state  = S_L_CHK;
            end
            S_L_CHK: begin
                n_flen = w_flen[hlef_pkg::CNT_W-1:0];
                n_copy = ({1'b0, w_pl} < {10'd0, r_want}) ? w_pl[6:0] : r_want;
                if (w_flen > hlef_pkg::FLEN_W'(hlef_pkg::BUFFER_DEPTH)) begin
                    n_off   = hlef_pkg::ADDR_W'(1);
                    n_dropn = hlef_pkg::CNT_W'(1);
                    n_state = S_DROP;
                end else if (w_fill_ext < w_flen) begin
                    n_strobe = 1'b1;
                    n_pbyte  = '0;
                    n_copied = '0;
                    n_status = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_off   = w_flen[hlef_pkg::ADDR_W-1:0] - hlef_pkg::ADDR_W'(1);
                    n_state = S_E_RD;
                end
            end
            S_E_RD: begin
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (w_q != hlef_pkg::END_BYTE) begin
                    n_off   = hlef_pkg::ADDR_W'(1);
                    n_dropn = hlef_pkg::CNT_W'(1);
                    n_state = S_DROP;
                end else if (r_copy == '0) begin
                    n_strobe = 1'b1;
                    n_pbyte  = '0;
                    n_copied = '0;
                    n_status = 1'b0;
                    n_last   = 1'b1;
                    n_done   = 1'b1;
                    n_off    = r_flen[hlef_pkg::ADDR_W-1:0];
                    n_dropn  = r_flen;
                    n_state  = S_DROP;
                end else begin
                    n_off   = hlef_pkg::ADDR_W'(hlef_pkg::OFF_PAYLOAD);
                    n_idx   = '0;
                    n_state = S_P_RD;
                end
            end
            S_P_RD: begin
                n_state = S_P_OUT;
            end
            S_P_OUT: begin
                n_strobe = 1'b1;
                n_pbyte  = w_q;
                n_copied = r_copy;
                n_status = 1'b0;
                n_last   = (w_idx_inc == r_copy);
                n_idx    = w_idx_inc;
                if (w_idx_inc == r_copy) begin
                    n_done  = 1'b1;
                    n_off   = r_flen[hlef_pkg::ADDR_W-1:0];
                    n_dropn = r_flen;
                    n_state = S_DROP;
                end else begin
                    n_off   = r_off + hlef_pkg::ADDR_W'(1);
                    n_state = S_P_RD;
                end
            end
            S_DROP: begin
                n_rp    = w_sum;
                n_fill  = r_fill - r_dropn;
                n_off   = '0;
                n_state = r_done ? S_IDLE : S_H_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
            r_done   <= n_done;
        end
        r_off    <= n_off;
        r_dropn  <= n_dropn;
        r_len_hi <= n_len_hi;
        r_flen   <= n_flen;
        r_want   <= n_want;
        r_copy   <= n_copy;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_last   <= n_last;
        r_pbyte  <= n_pbyte;
        r_copied <= n_copied;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_payload_byte = r_pbyte;
    assign o_copied_len   = r_copied;
    assign o_status       = r_status;
    assign o_last         = r_last;

endmodule

/* src/hlef_checker.sv */
// Port-level checks for the frame extractor, bound to the top level.
// Depends on hlef_pkg and head_length_end_frame_extractor.
module hlef_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic [7:0] o_payload_byte,
    input logic [6:0] o_copied_len,
    input logic       o_status,
    input logic       o_last
);

    a_nofr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> o_last)
        else $error("no-frame result without last");

    a_nofr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> (o_copied_len == 7'd0) && (o_payload_byte == 8'd0))
        else $error("no-frame result carries data");

    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> !o_strobe ##1 (o_strobe && !o_status))
        else $error("payload word missing after non-last word");

    a_len_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> ##2 (o_copied_len == $past(o_copied_len, 2)))
        else $error("copied length changed within a take");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_copied_len <= 7'(hlef_pkg::MAX_COPY)))
        else $error("copied length above limit");

endmodule

bind head_length_end_frame_extractor hlef_checker u_hlef_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_strobe       (o_strobe),
    .o_payload_byte (o_payload_byte),
    .o_copied_len   (o_copied_len),
    .o_status       (o_status),
    .o_last         (o_last)
);

/* test/hlef_frame_checker.sv */
`timescale 1ns / 100ps
// Checker for the head/length/end frame extractor: keeps a shadow byte buffer,
// predicts the words of each take and compares them as they are strobed out.
// Depends on hlef_pkg.
module hlef_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_request_len,
    input  logic       i_strobe,
    input  logic [7:0] i_payload_byte,
    input  logic [6:0] i_copied_len,
    input  logic       i_status,
    input  logic       i_last,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] payload;
        logic [6:0] copied;
        logic       status;
        logic       last;
    } t_frame_word;

    logic [7:0]  shadow_bytes [hlef_pkg::BUFFER_DEPTH];
    int          rd_ptr;
    int          wr_ptr;
    int          fill;
    t_frame_word frame_words_due [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        rd_ptr    = 0;
        wr_ptr    = 0;
        fill      = 0;
    end

    function automatic logic [7:0] peek(input int offset);
        return shadow_bytes[(rd_ptr + offset) % hlef_pkg::BUFFER_DEPTH];
    endfunction

    function automatic void discard(input int n);
        rd_ptr = (rd_ptr + n) % hlef_pkg::BUFFER_DEPTH;
        fill   = fill - n;
    endfunction

    function automatic void queue_word(input logic [7:0] b, input logic [6:0] n,
                                       input logic st, input logic lst);
        t_frame_word w;
        w.payload = b;
        w.copied  = n;
        w.status  = st;
        w.last    = lst;
        frame_words_due.push_back(w);
    endfunction

    // Scan for one frame and queue the words it produces.
    function automatic void extract_frame(input logic [6:0] req);
        int want;
        int plen;
        int flen;
        int ncopy;
        bit stop;
        want = (int'(req) > hlef_pkg::MAX_COPY) ? hlef_pkg::MAX_COPY : int'(req);
        stop = 1'b0;
        while (fill > 0 && !stop) begin
            if (peek(0) != hlef_pkg::HEAD_BYTE) begin
                discard(1);
            end else if (fill < hlef_pkg::FRAME_OVERHEAD) begin
                stop = 1'b1;
            end else begin
                plen = int'(peek(hlef_pkg::OFF_LEN_HI)) * 256
                       + int'(peek(hlef_pkg::OFF_LEN_LO));
                flen = plen + hlef_pkg::FRAME_OVERHEAD;
                if (flen > hlef_pkg::BUFFER_DEPTH) begin
                    discard(1);
                end else if (fill < flen) begin
                    stop = 1'b1;
                end else if (peek(flen - 1) != hlef_pkg::END_BYTE) begin
                    discard(1);
                end else begin
                    ncopy = (plen < want) ? plen : want;
                    if (ncopy == 0)
                        queue_word(8'h00, 7'd0, 1'b0, 1'b1);
                    for (int i = 0; i < ncopy; i++)
                        queue_word(peek(hlef_pkg::OFF_PAYLOAD + i), 7'(ncopy), 1'b0,
                                   i + 1 == ncopy);
                    discard(flen);
                    return;
                end
            end
        end
        queue_word(8'h00, 7'd0, 1'b1, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_frame_word got;
        t_frame_word exp;
        if (!i_rst_n) begin
            rd_ptr = 0;
            wr_ptr = 0;
            fill   = 0;
            frame_words_due.delete();
        end else begin
            if (i_strobe) begin
                got = '{i_payload_byte, i_copied_len, i_status, i_last};
                if (frame_words_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word: payload=%h copied=%0d status=%0d last=%0d",
                             $time, got.payload, got.copied, got.status, got.last);
                end else begin
                    exp = frame_words_due.pop_front();
                    if (got.payload !== exp.payload || got.copied !== exp.copied ||
                        got.status !== exp.status || got.last !== exp.last) begin
                        o_errors++;
                        $display({"%0t: word mismatch: expected payload=%h copied=%0d",
                                  " status=%0d last=%0d, actual payload=%h copied=%0d",
                                  " status=%0d last=%0d"},
                                 $time, exp.payload, exp.copied, exp.status, exp.last,
                                 got.payload, got.copied, got.status, got.last);
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_action)
                    hlef_pkg::ACT_PUSH: begin
                        if (fill < hlef_pkg::BUFFER_DEPTH) begin
                            shadow_bytes[wr_ptr] = i_data_byte;
                            wr_ptr = (wr_ptr + 1) % hlef_pkg::BUFFER_DEPTH;
                            fill++;
                        end
                    end
                    hlef_pkg::ACT_TAKE:  extract_frame(i_request_len);
                    hlef_pkg::ACT_CLEAR: begin
                        rd_ptr = 0;
                        wr_ptr = 0;
                        fill   = 0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending = frame_words_due.size();
    end

endmodule

/* test/tb_head_length_end_frame_extractor.sv */
`timescale 1ns / 100ps
// Testbench top for the head/length/end frame extractor: clock, reset, stimulus
// and verdict. Depends on hlef_pkg, the extractor and hlef_frame_checker.
module tb_head_length_end_frame_extractor;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 64;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_action;
    logic [7:0] i_data_byte;
    logic [6:0] i_request_len;
    logic       o_strobe;
    logic [7:0] o_payload_byte;
    logic [6:0] o_copied_len;
    logic       o_status;
    logic       o_last;

    int         errors;
    int         pending;
    int         idle_cycles = 0;
    int         n_items = 0;
    bit         gaps_on = 1'b1;
    logic [7:0] frame_bytes [$];

    head_length_end_frame_extractor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_request_len  (i_request_len),
        .o_strobe       (o_strobe),
        .o_payload_byte (o_payload_byte),
        .o_copied_len   (o_copied_len),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    hlef_frame_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_request_len  (i_request_len),
        .i_strobe       (o_strobe),
        .i_payload_byte (o_payload_byte),
        .i_copied_len   (o_copied_len),
        .i_status       (o_status),
        .i_last         (o_last),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_head_length_end_frame_extractor: errors");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [7:0] b,
                             input logic [6:0] req);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_data_byte   <= b;
        i_request_len <= req;
        do @(posedge i_clk); while (busy);
        if (act != ACT_UNUSED)
            n_items++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_word(hlef_pkg::ACT_PUSH, b, 7'($urandom));
    endtask

    task automatic take(input logic [6:0] req);
        send_word(hlef_pkg::ACT_TAKE, 8'($urandom), req);
    endtask

    task automatic clear_buffer();
        send_word(hlef_pkg::ACT_CLEAR, 8'($urandom), 7'($urandom));
    endtask

    // head, type, command, length, payload, checksum, end
    task automatic assemble_frame(input int plen, input bit bad_end);
        logic [7:0] tail;
        frame_bytes.delete();
        frame_bytes.push_back(hlef_pkg::HEAD_BYTE);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'(plen >> 8));
        frame_bytes.push_back(8'(plen));
        repeat (plen) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        tail = hlef_pkg::END_BYTE;
        if (bad_end)
            do tail = 8'($urandom); while (tail == hlef_pkg::END_BYTE);
        frame_bytes.push_back(tail);
    endtask

    task automatic push_span(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            push_byte(frame_bytes[i]);
    endtask

    task automatic send_frame(input int plen, input bit bad_end);
        assemble_frame(plen, bad_end);
        push_span(0, frame_bytes.size());
    endtask

    function automatic logic [6:0] pick_req();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'($urandom_range(65, 127));
            2:       return 7'(hlef_pkg::MAX_COPY);
            default: return 7'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic int pick_len();
        return $urandom_range(0, 12);
    endfunction

    initial begin
        int cut;
        int big_len;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_action      <= hlef_pkg::ACT_PUSH;
        i_data_byte   <= 8'h00;
        i_request_len <= 7'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        take(7'd0);
        send_word(ACT_UNUSED, 8'hFF, 7'h7F);
        push_byte(hlef_pkg::HEAD_BYTE);
        take(7'd1);
        clear_buffer();
        send_frame(0, 1'b0);
        take(7'd5);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(2, 1'b1);
        send_frame(1, 1'b0);
        take(7'd64);
        push_byte(hlef_pkg::HEAD_BYTE);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        take(7'd10);
        assemble_frame(10, 1'b0);
        push_span(0, 12);
        take(7'd127);
        push_span(12, frame_bytes.size());
        take(7'd127);
        send_frame(3, 1'b0);
        take(7'd0);

        // random
        while (n_items < 105) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
                1: begin
                    big_len = $urandom_range(hlef_pkg::BUFFER_DEPTH
                                             - hlef_pkg::FRAME_OVERHEAD + 1, 65535);
                    push_byte(hlef_pkg::HEAD_BYTE);
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                    push_byte(8'(big_len >> 8));
                    push_byte(8'(big_len));
                    repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
                end
                2: begin
                    if ($urandom_range(0, 2) == 0)
                        clear_buffer();
                    else
                        send_word(ACT_UNUSED, 8'($urandom), 7'($urandom));
                end
                3: begin
                    assemble_frame(pick_len(), 1'b0);
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    push_span(0, cut);
                    take(pick_req());
                    push_span(cut, frame_bytes.size());
                end
                default: send_frame(pick_len(), $urandom_range(0, 5) == 0);
            endcase
            if ($urandom_range(0, 3) != 0)
                take(pick_req());
        end

        // long payload, copy saturated, no gaps
        gaps_on = 1'b0;
        clear_buffer();
        send_frame(65, 1'b0);
        take(7'd127);

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb_head_length_end_frame_extractor: clean");
        else
            $display("tb_head_length_end_frame_extractor: errors");
        $finish;
    end

endmodule

/* filelist.f */
src/hlef_pkg.sv
src/hlef_ram.sv
src/hlef_offset_unit.sv
src/head_length_end_frame_extractor.sv
src/hlef_checker.sv
test/hlef_frame_checker.sv
test/tb_head_length_end_frame_extractor.sv
